@@ sv/lfu_frame_with_age_tiebreak_macros.svh @@
// Assertion macros shared by the frame logic; each assumes clk and rst_n in scope.
`ifndef LFU_FRAME_WITH_AGE_TIEBREAK_MACROS_SVH
`define LFU_FRAME_WITH_AGE_TIEBREAK_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define LFUF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame check failed");
// Consequent must hold in the cycle after the antecedent.
`define LFUF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame check failed");
`else
`define LFUF_ASSERT_SAME(lbl, ante, cons)
`define LFUF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/lfuf_pkg.sv @@
// Shared types and codes of the frame: cell commands, opcodes and the cell control struct.
package lfuf_pkg;

  // Count field width and its saturation value.
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Input opcodes.
  localparam logic OP_VOTE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Commands broadcast to every cell of the chain.
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_NOP    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INC    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MARK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLR    = 3'd5;

  // Control broadcast from the sequencer to the cells.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             scan_max;
  } ctrl_t;

endpackage

@@ sv/lfuf_cell.sv @@
// One frame slot: holds an id and a count, and passes the running best of a scan to its right.
module lfuf_cell #(
  parameter int ID_BITS  = 7,
  parameter int IDX_W    = 4,
  parameter int FILL_W   = 5,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfuf_pkg::ctrl_t             ctrl,
  input  logic [FILL_W-1:0]           fill,
  input  logic [IDX_W-1:0]            tgt,
  input  logic [ID_BITS-1:0]          cand,
  input  logic [ID_BITS-1:0]          nbr_id,
  input  logic [lfuf_pkg::CNT_W-1:0]  nbr_cnt,
  output logic [ID_BITS-1:0]          slot_id,
  output logic [lfuf_pkg::CNT_W-1:0]  slot_cnt,
  output logic                        hit,
  input  logic                        tin_vld,
  input  logic                        tin_found,
  input  logic [lfuf_pkg::CNT_W-1:0]  tin_cnt,
  input  logic [ID_BITS-1:0]          tin_id,
  input  logic [IDX_W-1:0]            tin_idx,
  output logic                        tout_vld,
  output logic                        tout_found,
  output logic [lfuf_pkg::CNT_W-1:0]  tout_cnt,
  output logic [ID_BITS-1:0]          tout_id,
  output logic [IDX_W-1:0]            tout_idx
);
  import lfuf_pkg::*;

  localparam logic [FILL_W-1:0] MY_POS = FILL_W'(CELL_IDX);
  localparam logic [IDX_W-1:0]  MY_IDX = IDX_W'(CELL_IDX);

  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               taken_r, taken_nxt;
  logic               occ, elig, better, take;
  logic               tok_vld_r, tok_found_r;
  logic [CNT_W-1:0]   tok_cnt_r;
  logic [ID_BITS-1:0] tok_id_r;
  logic [IDX_W-1:0]   tok_idx_r;

  // Slot is occupied when it lies below the fill level.
  assign occ     = (MY_POS < fill);
  assign hit     = occ && (id_r == cand);
  assign slot_id = id_r;
  assign slot_cnt = cnt_r;

  // Scan step: strict compare keeps the earlier slot on a tie.
  assign elig   = occ && (!ctrl.scan_max || !taken_r);
  assign better = ctrl.scan_max ? (cnt_r > tin_cnt) : (cnt_r < tin_cnt);
  assign take   = elig && (!tin_found || better);

  // Slot update for the broadcast command.
  always_comb begin
    id_nxt    = id_r;
    cnt_nxt   = cnt_r;
    taken_nxt = taken_r;
    unique case (ctrl.cmd)
      CMD_NOP: begin
      end
      CMD_INC: begin
        if (hit && (cnt_r != COUNT_MAX)) cnt_nxt = cnt_r + CNT_W'(1);
      end
      CMD_APPEND: begin
        if (MY_POS == fill) begin
          id_nxt  = cand;
          cnt_nxt = CNT_W'(1);
        end
      end
      CMD_SHIFT: begin
        if (MY_IDX >= tgt) begin
          id_nxt  = nbr_id;
          cnt_nxt = nbr_cnt;
        end
      end
      CMD_MARK: begin
        if (MY_IDX == tgt) taken_nxt = 1'b1;
      end
      CMD_CLR: begin
        taken_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Slot contents carry no reset.
  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cnt_r <= cnt_nxt;
  end

  // Control flags of the slot and the scan token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      taken_r   <= taken_nxt;
      tok_vld_r <= tin_vld;
    end
  end

  // Token payload: keep the incoming best or replace it with this slot.
  always_ff @(posedge clk) begin
    if (take) begin
      tok_found_r <= 1'b1;
      tok_cnt_r   <= cnt_r;
      tok_id_r    <= id_r;
      tok_idx_r   <= MY_IDX;
    end else begin
      tok_found_r <= tin_found;
      tok_cnt_r   <= tin_cnt;
      tok_id_r    <= tin_id;
      tok_idx_r   <= tin_idx;
    end
  end

  assign tout_vld   = tok_vld_r;
  assign tout_found = tok_found_r;
  assign tout_cnt   = tok_cnt_r;
  assign tout_id    = tok_id_r;
  assign tout_idx   = tok_idx_r;

endmodule

@@ sv/lfu_frame_with_age_tiebreak.sv @@
// Top level of the LFU frame: sequencer, fill level, result register and the chain of slot cells.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_op, in_candidate
//   out      output     out_valid / out_ready out_candidate_id, out_vote_count,
//                                             out_valid_res, out_last
//
// A vote that hits a resident id or finds room passes through S_VOTE and back to idle.
// A vote into a full frame runs a min scan down the cell chain, then shifts the chosen slot out.
// A report of n entries runs one max scan per entry, the token walking one cell per cycle;
// an empty frame gives one beat.
// Synchronous reset empties the frame; no clearing pass is needed.
// A stalled result holds the next report scan until the result register frees.
module lfu_frame_with_age_tiebreak #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [ID_BITS-1:0]          in_candidate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ID_BITS-1:0]          out_candidate_id,
  output logic [lfuf_pkg::CNT_W-1:0]  out_vote_count,
  output logic                        out_valid_res,
  output logic                        out_last
);
  import lfuf_pkg::*;

  `include "lfu_frame_with_age_tiebreak_macros.svh"

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(SLOTS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_VOTE   = 3'd1;
  localparam logic [2:0] S_EVSCAN = 3'd2;
  localparam logic [2:0] S_RSTART = 3'd3;
  localparam logic [2:0] S_RSCAN  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [FILL_W-1:0]  kcnt_r, kcnt_nxt;
  logic [ID_BITS-1:0] cand_r, cand_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [ID_BITS-1:0] out_id_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_res_r, out_last_r;
  logic               load_res, load_empty, res_last;
  logic               out_free, any_hit, scan_go;
  ctrl_t              ctrl;

  logic [SLOTS-1:0]   hit;
  logic [ID_BITS-1:0] cid  [SLOTS];
  logic [CNT_W-1:0]   ccnt [SLOTS];
  logic [SLOTS:0]     t_vld;
  logic [SLOTS:0]     t_found;
  logic [CNT_W-1:0]   t_cnt [SLOTS+1];
  logic [ID_BITS-1:0] t_id  [SLOTS+1];
  logic [IDX_W-1:0]   t_idx [SLOTS+1];

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_vld_r || out_ready;
  assign any_hit  = |hit;
  assign res_last = ((kcnt_r + FILL_W'(1)) == fill_r);

  // Scan token enters at the oldest slot with nothing found yet.
  assign t_vld[0]   = scan_go;
  assign t_found[0] = 1'b0;
  assign t_cnt[0]   = '0;
  assign t_id[0]    = '0;
  assign t_idx[0]   = '0;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    kcnt_nxt      = kcnt_r;
    cand_nxt      = cand_r;
    ctrl.cmd      = CMD_NOP;
    ctrl.scan_max = (state_r == S_RSTART) || (state_r == S_RSCAN);
    scan_go       = 1'b0;
    load_res      = 1'b0;
    load_empty    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cand_nxt = in_candidate;
          if (in_op == OP_REPORT) begin
            ctrl.cmd  = CMD_CLR;
            kcnt_nxt  = '0;
            state_nxt = S_RSTART;
          end else begin
            state_nxt = S_VOTE;
          end
        end
      end
      S_VOTE: begin
        if (any_hit) begin
          ctrl.cmd  = CMD_INC;
          state_nxt = S_IDLE;
        end else if (fill_r != FULL) begin
          ctrl.cmd  = CMD_APPEND;
          fill_nxt  = fill_r + FILL_W'(1);
          state_nxt = S_IDLE;
        end else begin
          scan_go   = 1'b1;
          state_nxt = S_EVSCAN;
        end
      end
      S_EVSCAN: begin
        if (t_vld[SLOTS]) begin
          ctrl.cmd  = CMD_SHIFT;
          state_nxt = S_IDLE;
        end
      end
      S_RSTART: begin
        if (out_free) begin
          if (fill_r == '0) begin
            load_empty = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            scan_go   = 1'b1;
            state_nxt = S_RSCAN;
          end
        end
      end
      S_RSCAN: begin
        if (t_vld[SLOTS]) begin
          load_res  = 1'b1;
          ctrl.cmd  = CMD_MARK;
          kcnt_nxt  = kcnt_r + FILL_W'(1);
          state_nxt = res_last ? S_IDLE : S_RSTART;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_vld_nxt = out_vld_r && !out_ready;
    if (load_res || load_empty) out_vld_nxt = 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      kcnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      kcnt_r    <= kcnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: latched candidate and the result beat.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (load_res) begin
      out_id_r   <= t_id[SLOTS];
      out_cnt_r  <= t_cnt[SLOTS];
      out_res_r  <= 1'b1;
      out_last_r <= res_last;
    end else if (load_empty) begin
      out_id_r   <= '0;
      out_cnt_r  <= '0;
      out_res_r  <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_candidate_id = out_id_r;
  assign out_vote_count   = out_cnt_r;
  assign out_valid_res    = out_res_r;
  assign out_last         = out_last_r;

  // Chain of slot cells, oldest at index 0; the newest takes the new id on a shift.
  for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
    logic [ID_BITS-1:0] nbr_id;
    logic [CNT_W-1:0]   nbr_cnt;
    if (gi == SLOTS - 1) begin : g_tail
      assign nbr_id  = cand_r;
      assign nbr_cnt = CNT_W'(1);
    end else begin : g_body
      assign nbr_id  = cid[gi+1];
      assign nbr_cnt = ccnt[gi+1];
    end
    lfuf_cell #(
      .ID_BITS  (ID_BITS),
      .IDX_W    (IDX_W),
      .FILL_W   (FILL_W),
      .CELL_IDX (gi)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .fill       (fill_r),
      .tgt        (t_idx[SLOTS]),
      .cand       (cand_r),
      .nbr_id     (nbr_id),
      .nbr_cnt    (nbr_cnt),
      .slot_id    (cid[gi]),
      .slot_cnt   (ccnt[gi]),
      .hit        (hit[gi]),
      .tin_vld    (t_vld[gi]),
      .tin_found  (t_found[gi]),
      .tin_cnt    (t_cnt[gi]),
      .tin_id     (t_id[gi]),
      .tin_idx    (t_idx[gi]),
      .tout_vld   (t_vld[gi+1]),
      .tout_found (t_found[gi+1]),
      .tout_cnt   (t_cnt[gi+1]),
      .tout_id    (t_id[gi+1]),
      .tout_idx   (t_idx[gi+1])
    );
  end

  // Checks on the frame logic.
  `LFUF_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FULL)
  `LFUF_ASSERT_SAME(a_no_dup_id, 1'b1, $onehot0(hit))
  `LFUF_ASSERT_SAME(a_tok_in_scan, t_vld[SLOTS], state_r == S_EVSCAN || state_r == S_RSCAN)
  `LFUF_ASSERT_SAME(a_tok_found, t_vld[SLOTS], t_found[SLOTS])
  `LFUF_ASSERT_SAME(a_empty_last, out_vld_r && !out_res_r, out_last_r)
  `LFUF_ASSERT_NEXT(a_append_fill, ctrl.cmd == CMD_APPEND, fill_r == $past(fill_r) + FILL_W'(1))

endmodule
